// ===== hdl/nprt_pkg.sv =====
// ----------------------------------------------------------------------------
// nprt_pkg
// Shared types and codes for the nearest-point-in-range table.
// ----------------------------------------------------------------------------
package nprt_pkg;

  localparam logic [2:0] ACT_REGISTER   = 3'd0;
  localparam logic [2:0] ACT_UNREGISTER = 3'd1;
  localparam logic [2:0] ACT_UPDATE     = 3'd2;
  localparam logic [2:0] ACT_IGNORE     = 3'd3;
  localparam logic [2:0] ACT_NEAREST    = 3'd4;
  localparam logic [2:0] ACT_COLLECT    = 3'd5;

  localparam logic [2:0] STS_OK        = 3'd0;
  localparam logic [2:0] STS_DUP       = 3'd1;
  localparam logic [2:0] STS_NOT_REG   = 3'd2;
  localparam logic [2:0] STS_NONE      = 3'd3;
  localparam logic [2:0] STS_BAD_ACT   = 3'd4;

  localparam int RESULT_CAP = 64;
  localparam int DIST_W     = 50;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic [2:0]         action;
    logic [5:0]         entity_id;
    logic signed [23:0] pos_x;
    logic signed [23:0] pos_y;
    logic               unavailable;
    logic [22:0]        range;
    logic [6:0]         limit;
    logic               sort_by_distance;
  } in_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [5:0]  result_id;
    logic [49:0] distance_sq;
    logic [6:0]  active_count;
    logic        last;
  } out_t;

  // Per-cycle command to every cell of the result chain
  typedef struct packed {
    logic clr;
    logic ins;
    logic pop;
    logic sorted;
  } cell_ctrl_t;

endpackage

// ===== hdl/nprt_ram.sv =====
// ----------------------------------------------------------------------------
// nprt_ram
// Generic single-port RAM, registered read.
// ----------------------------------------------------------------------------
module nprt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule

// ===== hdl/nprt_dist.sv =====
// ----------------------------------------------------------------------------
// nprt_dist
// Three-stage squared-distance unit: abs diff, square, sum.
// ----------------------------------------------------------------------------
module nprt_dist
  import nprt_pkg::*;
#(
  parameter int C  = 24,
  parameter int IW = 6
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                vld_i,
  input  logic [IW-1:0]       id_i,
  input  logic                ok_i,
  input  logic signed [C-1:0] ox_i,
  input  logic signed [C-1:0] oy_i,
  input  logic signed [C-1:0] px_i,
  input  logic signed [C-1:0] py_i,
  output logic                vld_o,
  output logic [IW-1:0]       id_o,
  output logic                ok_o,
  output logic [2*C:0]        d_o,
  output logic                busy_o
);

  logic signed [C:0] dxs, dys;
  logic [C-1:0]      dx_d, dy_d, dx_q, dy_q;
  logic [2*C-1:0]    sx_q, sy_q;
  logic              v1_q, v2_q, ok1_q, ok2_q;
  logic [IW-1:0]     id1_q, id2_q;

  always_comb begin
    dxs  = {ox_i[C-1], ox_i} - {px_i[C-1], px_i};
    dys  = {oy_i[C-1], oy_i} - {py_i[C-1], py_i};
    dx_d = dxs[C] ? C'(-dxs) : dxs[C-1:0];
    dy_d = dys[C] ? C'(-dys) : dys[C-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q  <= 1'b0;
      v2_q  <= 1'b0;
      vld_o <= 1'b0;
    end else begin
      v1_q  <= vld_i;
      v2_q  <= v1_q;
      vld_o <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    dx_q  <= dx_d;
    dy_q  <= dy_d;
    id1_q <= id_i;
    ok1_q <= ok_i;
    sx_q  <= dx_q * dx_q;
    sy_q  <= dy_q * dy_q;
    id2_q <= id1_q;
    ok2_q <= ok1_q;
    d_o   <= {1'b0, sx_q} + {1'b0, sy_q};
    id_o  <= id2_q;
    ok_o  <= ok2_q;
  end

  assign busy_o = v1_q | v2_q | vld_o;

endmodule

// ===== hdl/nprt_cell.sv =====
// ----------------------------------------------------------------------------
// nprt_cell
// One cell of the insertion chain: holds one hit, shifts on insert or pop.
// ----------------------------------------------------------------------------
module nprt_cell
  import nprt_pkg::*;
#(
  parameter int IW = 6,
  parameter int DW = 49
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  cell_ctrl_t    ctrl_i,
  input  logic [IW-1:0] new_id_i,
  input  logic [DW-1:0] new_d_i,
  input  logic          prev_less_i,
  input  logic          prev_v_i,
  input  logic [IW-1:0] prev_id_i,
  input  logic [DW-1:0] prev_d_i,
  input  logic          next_v_i,
  input  logic [IW-1:0] next_id_i,
  input  logic [DW-1:0] next_d_i,
  output logic          less_o,
  output logic          v_o,
  output logic [IW-1:0] id_o,
  output logic [DW-1:0] d_o
);

  // new item goes in front of this cell's entry
  assign less_o = !v_o || (ctrl_i.sorted && (d_o > new_d_i));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_o <= 1'b0;
    end else if (ctrl_i.clr) begin
      v_o <= 1'b0;
    end else if (ctrl_i.pop) begin
      v_o <= next_v_i;
    end else if (ctrl_i.ins && less_o) begin
      v_o <= prev_less_i ? prev_v_i : 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.pop) begin
      id_o <= next_id_i;
      d_o  <= next_d_i;
    end else if (ctrl_i.ins && less_o) begin
      id_o <= prev_less_i ? prev_id_i : new_id_i;
      d_o  <= prev_less_i ? prev_d_i : new_d_i;
    end
  end

endmodule

// ===== hdl/nearest_point_in_range_table.sv =====
// ----------------------------------------------------------------------------
// nearest_point_in_range_table
// Table of 2D points per entity id with nearest and collect range queries.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i/in_ready_o/in_data_i) takes one action per
//   transaction; output channel (out_valid_o/out_ready_i/out_data_o) returns
//   its results, the final one flagged by last.
//   Register/unregister/update/ignore and bad codes: one result, loaded into
//   the output register the cycle after acceptance.
//   Queries: the slot counter issues one slot per cycle into the three-stage
//   distance unit behind the registered point RAM. Hits of a collect query
//   drop into a chain of cells that keeps them in id order or in distance
//   order (insertion per hit); results then pop off the chain head, one per
//   cycle while the receiver takes them.
//   One transaction is worked on at a time; the next is accepted once the
//   previous results are all handed off (the last one may still sit in the
//   output register being taken).
//   Reset clears all slot marks, the count and the chain; points in RAM are
//   undefined until written and never used for an empty slot.
//   A stalled receiver simply holds the output register and the chain.
// ----------------------------------------------------------------------------
module nearest_point_in_range_table
  import nprt_pkg::*;
#(
  parameter int TABLE_SLOTS = 64,
  parameter int COORD_BITS  = 24
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  in_t  in_data_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output out_t out_data_o
);

  localparam int C     = COORD_BITS;
  localparam int IW    = $clog2(TABLE_SLOTS);
  localparam int SW    = 2 * C + 1;
  localparam int NCELL = (TABLE_SLOTS < RESULT_CAP) ? TABLE_SLOTS : RESULT_CAP;
  localparam int CLW   = $clog2(TABLE_SLOTS + 1);
  localparam int CNTW  = (CLW > 7) ? CLW : 7;
  localparam int XW    = (IW > 6) ? IW : 6;
  localparam int CMPW  = (SW > 46) ? SW : 46;
  localparam int EW    = (SW > DIST_W) ? SW : DIST_W;

  state_e state_q, state_d;

  logic [TABLE_SLOTS-1:0] valid_q, unav_q, ign_q;
  logic [CNTW-1:0]        cnt_q, cnt_d;

  // query context
  logic signed [C-1:0] ox_q, oy_q;
  logic [22:0]         range_q;
  logic [6:0]          limit_q;
  logic                sorted_q, near_q;

  // scan
  logic [IW-1:0] sc_q;
  logic          issue_q;
  logic          s0_v_q, s0_ok_q;
  logic [IW-1:0] s0_id_q;

  // nearest tracking, collect counters
  logic          found_q;
  logic [IW-1:0] best_id_q;
  logic [SW-1:0] best_d_q;
  logic [6:0]    nhit_q, rem_q;

  logic out_valid_q;
  out_t out_q, out_d;
  logic out_load;

  // handshake and decode
  logic          in_fire, pop, scan_done, out_free;
  logic          in_tab;
  logic [IW-1:0] sidx;
  logic          is_query;
  logic [2:0]    sts;
  logic          wr_point;

  // ram
  logic [IW-1:0]    ram_addr;
  logic [2*C-1:0]   ram_rdata;

  // dist unit
  logic          dv;
  logic [IW-1:0] did;
  logic          dok;
  logic [SW-1:0] dd;
  logic          dbusy;

  logic [CMPW-1:0] d_ext, rsq_ext;
  logic            unlim, hit;

  // chain
  cell_ctrl_t    cctrl;
  logic          c_v    [NCELL];
  logic [IW-1:0] c_id   [NCELL];
  logic [SW-1:0] c_d    [NCELL];
  logic          c_less [NCELL];

  assign out_free = !out_valid_q || out_ready_i;
  assign in_fire  = in_valid_i && in_ready_o;
  assign in_tab   = 32'(in_data_i.entity_id) < TABLE_SLOTS;
  assign sidx     = IW'(in_data_i.entity_id);
  assign is_query = (in_data_i.action == ACT_NEAREST) || (in_data_i.action == ACT_COLLECT);

  // action decode: status and count after the action
  always_comb begin
    sts      = STS_OK;
    cnt_d    = cnt_q;
    wr_point = 1'b0;
    case (in_data_i.action)
      ACT_REGISTER: begin
        if (!in_tab) begin
          sts = STS_NOT_REG;
        end else if (valid_q[sidx]) begin
          sts = STS_DUP;
        end else begin
          wr_point = 1'b1;
          cnt_d    = cnt_q + CNTW'(1);
        end
      end
      ACT_UNREGISTER, ACT_UPDATE, ACT_IGNORE: begin
        if (!in_tab || !valid_q[sidx]) begin
          sts = STS_NOT_REG;
        end else if (in_data_i.action == ACT_UNREGISTER) begin
          if (cnt_q != '0) cnt_d = cnt_q - CNTW'(1);
        end else if (in_data_i.action == ACT_UPDATE) begin
          wr_point = 1'b1;
        end
      end
      ACT_NEAREST, ACT_COLLECT: sts = STS_OK;
      default: sts = STS_BAD_ACT;
    endcase
  end

  assign ram_addr = (state_q == ST_IDLE) ? sidx : sc_q;

  nprt_ram #(
    .WIDTH (2 * C),
    .DEPTH (TABLE_SLOTS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (in_fire && wr_point),
    .addr_i  (ram_addr),
    .wdata_i ({C'(in_data_i.pos_x), C'(in_data_i.pos_y)}),
    .rdata_o (ram_rdata)
  );

  nprt_dist #(
    .C  (C),
    .IW (IW)
  ) u_dist (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .vld_i  (s0_v_q),
    .id_i   (s0_id_q),
    .ok_i   (s0_ok_q),
    .ox_i   (ox_q),
    .oy_i   (oy_q),
    .px_i   (ram_rdata[2*C-1:C]),
    .py_i   (ram_rdata[C-1:0]),
    .vld_o  (dv),
    .id_o   (did),
    .ok_o   (dok),
    .d_o    (dd),
    .busy_o (dbusy)
  );

  // range test: strict for nearest, inclusive for collect
  always_comb begin
    unlim   = (range_q == '0);
    d_ext   = CMPW'(dd);
    rsq_ext = CMPW'(range_q * range_q);
    hit     = dv && dok && (unlim || (near_q ? (d_ext < rsq_ext) : (d_ext <= rsq_ext)));
  end

  assign scan_done = (state_q == ST_SCAN) && !issue_q && !s0_v_q && !dbusy;
  assign pop       = (state_q == ST_EMIT) && out_free;

  always_comb begin
    cctrl.clr    = in_fire && (in_data_i.action == ACT_COLLECT);
    cctrl.ins    = hit && !near_q;
    cctrl.pop    = pop;
    cctrl.sorted = sorted_q;
  end

  for (genvar i = 0; i < NCELL; i++) begin : g_cell
    nprt_cell #(
      .IW (IW),
      .DW (SW)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctrl_i      (cctrl),
      .new_id_i    (did),
      .new_d_i     (dd),
      .prev_less_i ((i == 0) ? 1'b0 : c_less[(i == 0) ? 0 : i - 1]),
      .prev_v_i    (c_v[(i == 0) ? 0 : i - 1]),
      .prev_id_i   (c_id[(i == 0) ? 0 : i - 1]),
      .prev_d_i    (c_d[(i == 0) ? 0 : i - 1]),
      .next_v_i    ((i == NCELL - 1) ? 1'b0 : c_v[(i == NCELL - 1) ? i : i + 1]),
      .next_id_i   (c_id[(i == NCELL - 1) ? i : i + 1]),
      .next_d_i    (c_d[(i == NCELL - 1) ? i : i + 1]),
      .less_o      (c_less[i]),
      .v_o         (c_v[i]),
      .id_o        (c_id[i]),
      .d_o         (c_d[i])
    );
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (in_fire && is_query) state_d = ST_SCAN;
      ST_SCAN: if (scan_done) state_d = (!near_q && nhit_q != '0) ? ST_EMIT : ST_IDLE;
      ST_EMIT: if (pop && rem_q == 7'd1) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  function automatic logic [5:0] id6(input logic [IW-1:0] v);
    logic [XW-1:0] t;
    t = XW'(v);
    return t[5:0];
  endfunction

  function automatic logic [DIST_W-1:0] dsat(input logic [SW-1:0] v);
    logic [EW-1:0] t;
    t = EW'(v);
    return (t > EW'({DIST_W{1'b1}})) ? {DIST_W{1'b1}} : t[DIST_W-1:0];
  endfunction

  // outputs: in_ready and output register load
  always_comb begin
    in_ready_o = (state_q == ST_IDLE) && out_free;
    out_load   = 1'b0;
    out_d      = out_q;
    case (state_q)
      ST_IDLE: begin
        if (in_fire && !is_query) begin
          out_load = 1'b1;
          out_d    = '{status: sts, result_id: '0, distance_sq: '0,
                       active_count: cnt_d[6:0], last: 1'b1};
        end
      end
      ST_SCAN: begin
        if (scan_done && (near_q || nhit_q == '0)) begin
          out_load = 1'b1;
          if (near_q && found_q) begin
            out_d = '{status: STS_OK, result_id: id6(best_id_q),
                      distance_sq: dsat(best_d_q), active_count: cnt_q[6:0], last: 1'b1};
          end else begin
            out_d = '{status: STS_NONE, result_id: '0, distance_sq: '0,
                      active_count: cnt_q[6:0], last: 1'b1};
          end
        end
      end
      ST_EMIT: begin
        if (pop) begin
          out_load = 1'b1;
          out_d    = '{status: STS_OK, result_id: id6(c_id[0]), distance_sq: dsat(c_d[0]),
                       active_count: cnt_q[6:0], last: (rem_q == 7'd1)};
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      valid_q     <= '0;
      unav_q      <= '0;
      ign_q       <= '0;
      cnt_q       <= '0;
      issue_q     <= 1'b0;
      sc_q        <= '0;
      s0_v_q      <= 1'b0;
      found_q     <= 1'b0;
      nhit_q      <= '0;
      rem_q       <= '0;
      out_valid_q <= 1'b0;
      near_q      <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end

      if (in_fire) begin
        cnt_q <= cnt_d;
        if (sts == STS_OK) begin
          case (in_data_i.action)
            ACT_REGISTER: begin
              valid_q[sidx] <= 1'b1;
              unav_q[sidx]  <= 1'b0;
              ign_q[sidx]   <= 1'b0;
            end
            ACT_UNREGISTER: begin
              valid_q[sidx] <= 1'b0;
              unav_q[sidx]  <= 1'b0;
              ign_q[sidx]   <= 1'b0;
            end
            ACT_UPDATE: unav_q[sidx] <= in_data_i.unavailable;
            ACT_IGNORE: ign_q[sidx]  <= 1'b1;
            default: ;
          endcase
        end
        if (is_query) begin
          near_q  <= (in_data_i.action == ACT_NEAREST);
          issue_q <= 1'b1;
          sc_q    <= '0;
          found_q <= 1'b0;
          nhit_q  <= '0;
        end
      end

      // slot issue
      s0_v_q <= issue_q;
      if (issue_q) begin
        if (32'(sc_q) == TABLE_SLOTS - 1) begin
          issue_q <= 1'b0;
        end else begin
          sc_q <= sc_q + IW'(1);
        end
      end

      if (hit && near_q && (!found_q || dd < best_d_q)) begin
        found_q <= 1'b1;
      end
      if (hit && !near_q && 32'(nhit_q) < NCELL) begin
        nhit_q <= nhit_q + 7'd1;
      end

      if (scan_done) begin
        if (near_q) ign_q <= '0;
        rem_q <= (limit_q != '0 && nhit_q > limit_q) ? limit_q : nhit_q;
      end else if (pop) begin
        rem_q <= rem_q - 7'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire && is_query) begin
      ox_q     <= C'(in_data_i.pos_x);
      oy_q     <= C'(in_data_i.pos_y);
      range_q  <= in_data_i.range;
      limit_q  <= in_data_i.limit;
      sorted_q <= in_data_i.sort_by_distance;
    end
    s0_id_q <= sc_q;
    s0_ok_q <= valid_q[sc_q] && !unav_q[sc_q] && !(near_q && ign_q[sc_q]);
    if (hit && near_q && (!found_q || dd < best_d_q)) begin
      best_id_q <= did;
      best_d_q  <= dd;
    end
    if (out_load) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef SYNTH
  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> (state_q == ST_IDLE))
    else $error("input taken outside idle");
  a_scan_out_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |-> !out_valid_q)
    else $error("result pending during scan");
  a_emit_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT) |-> (rem_q != '0) && c_v[0])
    else $error("emit with empty chain");
  a_hit_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(nhit_q) <= NCELL)
    else $error("hit count overflow");
`endif

endmodule
